[src/crc16_packet_framer_unit_macros.svh]
// Assertion helpers for the framer RTL, used by its burst serializer.
`ifndef CRC16_PACKET_FRAMER_UNIT_MACROS_SVH
`define CRC16_PACKET_FRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked under reset-gating.
`define CPF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Checked on every edge, reset included.
`define CPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPF_ASSERT(lbl, clk, rstn, prop, msg)
`define CPF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/crc16pf_pkg.sv]
package crc16pf_pkg;

  localparam logic [7:0]  FrameStart = 8'd2;
  localparam logic [7:0]  FrameStop  = 8'd3;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcTopBit  = 16'h8000;
  localparam int          MaxBurst   = 6;

  typedef logic [2:0] burst_cnt_t;

  // Up to six wire bytes produced by one accepted payload byte.
  // bytes[0] goes out first.
  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    burst_cnt_t               cnt;
    logic                     has_end;
  } burst_t;

  // CRC-16, poly 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTopBit) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/crc16pf_in_if.sv]
interface crc16pf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] payload_len;

  modport source (output valid, output payload_byte, output payload_len, input ready);
  modport sink (input valid, input payload_byte, input payload_len, output ready);
endinterface

[src/crc16pf_out_if.sv]
interface crc16pf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

[src/crc16pf_burst.sv]
`include "crc16_packet_framer_unit_macros.svh"

// Output serializer: holds one burst and drains it a byte per transaction.
module crc16pf_burst (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_en,
  input  crc16pf_pkg::burst_t   load_burst,
  output logic                  can_load,
  crc16pf_out_if.source         out_ch
);

  crc16pf_pkg::burst_t burst_r, burst_nxt;
  logic                pop;

  assign out_ch.valid     = (burst_r.cnt != 3'd0);
  assign out_ch.out_byte  = burst_r.bytes[0];
  assign out_ch.frame_end = burst_r.has_end && (burst_r.cnt == 3'd1);

  assign pop      = out_ch.valid && out_ch.ready;
  // Refill in the same cycle the last byte leaves.
  assign can_load = (burst_r.cnt == 3'd0) || ((burst_r.cnt == 3'd1) && out_ch.ready);

  always_comb begin
    burst_nxt = burst_r;
    if (load_en) begin
      burst_nxt = load_burst;
    end else if (pop) begin
      burst_nxt.bytes = burst_r.bytes >> 8;
      burst_nxt.cnt   = burst_r.cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r.cnt     <= '0;
      burst_r.has_end <= 1'b0;
    end else begin
      burst_r.cnt     <= burst_nxt.cnt;
      burst_r.has_end <= burst_nxt.has_end;
    end
    burst_r.bytes <= burst_nxt.bytes;
  end

  `CPF_ASSERT(a_cnt_range, clk, rst_n, (burst_r.cnt <= 3'(crc16pf_pkg::MaxBurst)), "burst count overflow")
  `CPF_ASSERT(a_end_byte, clk, rst_n, (out_ch.frame_end |-> (out_ch.out_byte == crc16pf_pkg::FrameStop)), "frame_end on a byte other than the stop byte")
  `CPF_ASSERT(a_no_overwrite, clk, rst_n, (load_en |-> can_load), "burst loaded while bytes still pending")
  `CPF_ASSERT(a_drain, clk, rst_n, ((pop && !load_en) |=> (burst_r.cnt == $past(burst_r.cnt) - 3'd1)), "burst count did not step on a transaction")

endmodule

[src/crc16_packet_framer_unit.sv]
// The first wire byte of an accepted payload byte is offered in the cycle after it.
// Throughput: one wire byte, and one middle payload byte, per cycle while out_ch is ready;
//   other bytes hold input while the single-byte serializer drains their burst: 3 bytes
//   for a frame's first, 4 for its last, 5 for an empty frame, 6 for a one-byte frame.
// Reset (rst_n, synchronous, active low): CRC and length counter clear, framer idle,
//   output burst empty.
module crc16_packet_framer_unit (
  input  logic          clk,
  input  logic          rst_n,
  crc16pf_in_if.sink    in_ch,
  crc16pf_out_if.source out_ch
);

  // Frame state: running CRC and remaining payload count (0 = between frames).
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  left_r, left_nxt;

  logic                accept;
  logic                can_load;
  logic                idle;
  logic                zero_len;
  logic                last;
  logic [15:0]         crc_base;
  logic [15:0]         crc_upd;
  logic [7:0]          left_base;
  logic [7:0]          left_dec;
  crc16pf_pkg::burst_t load_burst;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && in_ch.ready;

  // Per-byte update: a new frame starts from zero CRC and the sampled length.
  always_comb begin
    idle      = (left_r == 8'd0);
    zero_len  = idle && (in_ch.payload_len == 8'd0);
    crc_base  = idle ? 16'h0000 : crc_r;
    left_base = idle ? in_ch.payload_len : left_r;
    crc_upd   = crc16pf_pkg::crc_feed(crc_base, in_ch.payload_byte);
    left_dec  = left_base - 8'd1;
    last      = (left_dec == 8'd0);
  end

  // Assemble the wire bytes caused by this transaction.
  always_comb begin
    load_burst         = '0;
    if (zero_len) begin
      // Empty frame: header, CRC of nothing, stop. Payload byte is dropped.
      load_burst.bytes[0] = crc16pf_pkg::FrameStart;
      load_burst.bytes[1] = 8'h00;
      load_burst.bytes[2] = 8'h00;
      load_burst.bytes[3] = 8'h00;
      load_burst.bytes[4] = crc16pf_pkg::FrameStop;
      load_burst.cnt      = 3'd5;
      load_burst.has_end  = 1'b1;
    end else if (idle && last) begin
      load_burst.bytes[0] = crc16pf_pkg::FrameStart;
      load_burst.bytes[1] = in_ch.payload_len;
      load_burst.bytes[2] = in_ch.payload_byte;
      load_burst.bytes[3] = crc_upd[15:8];
      load_burst.bytes[4] = crc_upd[7:0];
      load_burst.bytes[5] = crc16pf_pkg::FrameStop;
      load_burst.cnt      = 3'd6;
      load_burst.has_end  = 1'b1;
    end else if (idle) begin
      load_burst.bytes[0] = crc16pf_pkg::FrameStart;
      load_burst.bytes[1] = in_ch.payload_len;
      load_burst.bytes[2] = in_ch.payload_byte;
      load_burst.cnt      = 3'd3;
    end else if (last) begin
      load_burst.bytes[0] = in_ch.payload_byte;
      load_burst.bytes[1] = crc_upd[15:8];
      load_burst.bytes[2] = crc_upd[7:0];
      load_burst.bytes[3] = crc16pf_pkg::FrameStop;
      load_burst.cnt      = 3'd4;
      load_burst.has_end  = 1'b1;
    end else begin
      load_burst.bytes[0] = in_ch.payload_byte;
      load_burst.cnt      = 3'd1;
    end
  end

  // CRC returns to zero once the trailer is queued.
  always_comb begin
    crc_nxt  = crc_r;
    left_nxt = left_r;
    if (accept) begin
      if (zero_len) begin
        crc_nxt  = 16'h0000;
        left_nxt = 8'd0;
      end else begin
        crc_nxt  = last ? 16'h0000 : crc_upd;
        left_nxt = left_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= 16'h0000;
      left_r <= 8'd0;
    end else begin
      crc_r  <= crc_nxt;
      left_r <= left_nxt;
    end
  end

  crc16pf_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (accept),
    .load_burst (load_burst),
    .can_load   (can_load),
    .out_ch     (out_ch)
  );

endmodule
